// File: rtl/uvs_pkg.sv
// shared types, constants and coefficient tables of the uv sphere vertex generator
`default_nettype none

package uvs_pkg;

    localparam int CNT_W     = 10;
    localparam int IDX_W     = 20;
    localparam int TEX_W     = 17;
    localparam int OUT_W     = 16;
    localparam int FRAC_BITS = 15;
    localparam int TURN_W    = 32;
    localparam int Q30_W     = 31;
    localparam int Q_W       = 34;
    localparam int DIV_STEPS = Q_W - 1;

    localparam logic [Q30_W-1:0]  Q30_ONE = 31'h4000_0000;
    localparam logic [TURN_W-1:0] PI_Q30  = 32'd3373259426;

    localparam int SIN_TERMS = 5;
    localparam int COS_TERMS = 6;

    localparam logic [63:0] TWO_POW_32 = 64'h1_0000_0000;

    localparam logic [7:0] SIN_DIV [SIN_TERMS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [7:0] COS_DIV [COS_TERMS] =
        '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

    // floor(2^32 / d), quotient estimate is exact or one low
    localparam logic [31:0] SIN_RCP [SIN_TERMS] = '{
        32'(TWO_POW_32 / 64'd110), 32'(TWO_POW_32 / 64'd72), 32'(TWO_POW_32 / 64'd42),
        32'(TWO_POW_32 / 64'd20), 32'(TWO_POW_32 / 64'd6)};
    localparam logic [31:0] COS_RCP [COS_TERMS] = '{
        32'(TWO_POW_32 / 64'd132), 32'(TWO_POW_32 / 64'd90), 32'(TWO_POW_32 / 64'd56),
        32'(TWO_POW_32 / 64'd30), 32'(TWO_POW_32 / 64'd12), 32'(TWO_POW_32 / 64'd2)};

    typedef struct packed {
        logic             in_range;
        logic             quad_valid;
        logic [IDX_W-1:0] vertex_index;
        logic [IDX_W-1:0] right_index;
        logic [IDX_W-1:0] up_index;
        logic [TEX_W-1:0] tex_u;
        logic [TEX_W-1:0] tex_v;
    } side_t;

    typedef struct packed {
        logic [OUT_W-1:0] pos_x;
        logic [OUT_W-1:0] pos_y;
        logic [OUT_W-1:0] pos_z;
        logic [OUT_W-1:0] tan_x;
        logic [OUT_W-1:0] tan_y;
        logic [TEX_W-1:0] tex_u;
        logic [TEX_W-1:0] tex_v;
        logic [IDX_W-1:0] vertex_index;
        logic [IDX_W-1:0] right_index;
        logic [IDX_W-1:0] up_index;
        logic             quad_valid;
        logic             in_range;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/uvs_divider.sv
// pipelined restoring divider giving the angle turn fractions and texture coordinates
`default_nettype none

module uvs_divider (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [uvs_pkg::CNT_W-1:0] row,
    input  logic [uvs_pkg::CNT_W-1:0] stacks,
    input  logic [uvs_pkg::CNT_W-1:0] col,
    input  logic [uvs_pkg::CNT_W-1:0] slices,
    input  uvs_pkg::side_t           in_side,
    output logic                     out_valid,
    output logic [uvs_pkg::TURN_W-1:0] turn_phi,
    output logic [uvs_pkg::TURN_W-1:0] turn_theta,
    output uvs_pkg::side_t           out_side
);
    import uvs_pkg::*;

    typedef struct packed {
        side_t            side;
        logic [CNT_W-1:0] rd;
        logic [CNT_W-1:0] cd;
        logic [CNT_W-1:0] rrem;
        logic [CNT_W-1:0] crem;
        logic [Q_W-1:0]   rq;
        logic [Q_W-1:0]   cq;
    } div_stage_t;

    function automatic div_stage_t div_step(input div_stage_t s);
        div_stage_t   n;
        logic [CNT_W:0] rr;
        logic [CNT_W:0] cr;
        n  = s;
        rr = {s.rrem, 1'b0};
        cr = {s.crem, 1'b0};
        if (rr >= {1'b0, s.rd})
        begin
            n.rrem = CNT_W'(rr - {1'b0, s.rd});
            n.rq   = {s.rq[Q_W-2:0], 1'b1};
        end
        else
        begin
            n.rrem = rr[CNT_W-1:0];
            n.rq   = {s.rq[Q_W-2:0], 1'b0};
        end
        if (cr >= {1'b0, s.cd})
        begin
            n.crem = CNT_W'(cr - {1'b0, s.cd});
            n.cq   = {s.cq[Q_W-2:0], 1'b1};
        end
        else
        begin
            n.crem = cr[CNT_W-1:0];
            n.cq   = {s.cq[Q_W-2:0], 1'b0};
        end
        return n;
    endfunction

    logic [DIV_STEPS:0] valid_reg;
    div_stage_t         stage_reg [0:DIV_STEPS];
    div_stage_t         first_next;

    logic               out_valid_reg;
    logic [TURN_W-1:0]  turn_phi_reg, turn_phi_next;
    logic [TURN_W-1:0]  turn_theta_reg, turn_theta_next;
    side_t              side_reg, side_next;

    logic [Q_W-1:0]     q_row;
    logic [Q_W-1:0]     q_col;
    logic [Q_W:0]       row_turn;
    logic [Q_W:0]       col_turn;
    logic [Q_W-16:0]    row_tex;
    logic [Q_W-16:0]    col_tex;

    // integer bit of the quotient
    always_comb
    begin
        first_next.side = in_side;
        first_next.rd   = stacks;
        first_next.cd   = slices;
        if (row >= stacks)
        begin
            first_next.rrem = row - stacks;
            first_next.rq   = Q_W'(1);
        end
        else
        begin
            first_next.rrem = row;
            first_next.rq   = '0;
        end
        if (col >= slices)
        begin
            first_next.crem = col - slices;
            first_next.cq   = Q_W'(1);
        end
        else
        begin
            first_next.crem = col;
            first_next.cq   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= {valid_reg[DIV_STEPS-1:0], in_valid};
            out_valid_reg <= valid_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg[0] <= first_next;
        for (int k = 1; k <= DIV_STEPS; k++)
        begin
            stage_reg[k] <= div_step(stage_reg[k-1]);
        end
    end

    // rounding half up from the extra quotient bit
    always_comb
    begin
        q_row          = stage_reg[DIV_STEPS].rq;
        q_col          = stage_reg[DIV_STEPS].cq;
        row_turn       = {2'b00, q_row[Q_W-1:1]} + (Q_W+1)'(1);
        col_turn       = {1'b0, q_col} + (Q_W+1)'(1);
        row_tex        = {1'b0, q_row[Q_W-1:16]} + (Q_W-15)'(1);
        col_tex        = {1'b0, q_col[Q_W-1:16]} + (Q_W-15)'(1);
        turn_phi_next   = row_turn[TURN_W:1];
        turn_theta_next = col_turn[TURN_W:1];
        side_next       = stage_reg[DIV_STEPS].side;
        side_next.tex_v = row_tex[TEX_W:1];
        side_next.tex_u = col_tex[TEX_W:1];
    end

    always_ff @(posedge clk)
    begin
        turn_phi_reg   <= turn_phi_next;
        turn_theta_reg <= turn_theta_next;
        side_reg       <= side_next;
    end

    assign out_valid  = out_valid_reg;
    assign turn_phi   = turn_phi_reg;
    assign turn_theta = turn_theta_reg;
    assign out_side   = side_reg;

endmodule

`default_nettype wire

// File: rtl/uvs_trig.sv
// pipelined fixed point sine and cosine of the polar and azimuth angles
`default_nettype none

module uvs_trig (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [uvs_pkg::TURN_W-1:0] turn_phi,
    input  logic [uvs_pkg::TURN_W-1:0] turn_theta,
    input  uvs_pkg::side_t             in_side,
    output logic                       out_valid,
    output logic signed [31:0]         sin_phi,
    output logic signed [31:0]         cos_phi,
    output logic signed [31:0]         sin_theta,
    output logic signed [31:0]         cos_theta,
    output uvs_pkg::side_t             out_side
);
    import uvs_pkg::*;

    localparam int HORNER_STAGES = 3 * COS_TERMS;
    localparam int TRIG_LAST     = 2 + HORNER_STAGES;

    localparam logic [1:0]  QUAD_FIRST  = 2'd0;
    localparam logic [1:0]  QUAD_SECOND = 2'd1;
    localparam logic [1:0]  QUAD_THIRD  = 2'd2;
    localparam logic [29:0] EIGHTH_TURN = 30'h2000_0000;

    typedef struct packed {
        logic [1:0]       quad;
        logic             swap;
        logic [29:0]      x;
        logic [29:0]      x2;
        logic [Q30_W-1:0] s_sin;
        logic [Q30_W-1:0] s_cos;
        logic [Q30_W-1:0] p_sin;
        logic [Q30_W-1:0] p_cos;
        logic [Q30_W-1:0] q_sin;
        logic [Q30_W-1:0] q_cos;
    } lane_t;

    typedef struct packed {
        side_t side;
        lane_t phi;
        lane_t th;
    } trig_stage_t;

    typedef struct packed {
        logic signed [31:0] sn;
        logic signed [31:0] cs;
    } sc_t;

    // quadrant and fold to the first eighth of a turn
    function automatic lane_t lane_fold(input logic [TURN_W-1:0] turn);
        lane_t n;
        n      = '0;
        n.quad = turn[31:30];
        n.swap = turn[29:0] > EIGHTH_TURN;
        n.x    = n.swap ? 30'(Q30_ONE - {1'b0, turn[29:0]}) : turn[29:0];
        return n;
    endfunction

    // fraction of a turn to radians
    function automatic lane_t lane_scale(input lane_t l);
        lane_t       n;
        logic [61:0] prod;
        n    = l;
        prod = 62'(l.x) * 62'(PI_Q30);
        prod = prod + 62'(Q30_ONE);
        n.x  = prod[60:31];
        return n;
    endfunction

    function automatic lane_t lane_square(input lane_t l);
        lane_t       n;
        logic [59:0] sq;
        n       = l;
        sq      = 60'(l.x) * 60'(l.x);
        n.x2    = sq[59:30];
        n.s_sin = Q30_ONE;
        n.s_cos = Q30_ONE;
        return n;
    endfunction

    // one third of a horner step: product, reciprocal estimate, correction
    function automatic lane_t lane_horner(input lane_t l, input int step, input int sub);
        lane_t       n;
        logic [60:0] pa;
        logic [62:0] pb;
        logic [38:0] qd;
        logic [31:0] r;
        logic        corr;
        n = l;
        case (sub)
            0:
            begin
                pa      = 61'(l.x2) * 61'(l.s_cos);
                n.p_cos = pa[60:30];
                if (step < SIN_TERMS)
                begin
                    pa      = 61'(l.x2) * 61'(l.s_sin);
                    n.p_sin = pa[60:30];
                end
                else
                begin
                    pa      = 61'(l.x) * 61'(l.s_sin);
                    n.s_sin = pa[60:30];
                end
            end
            1:
            begin
                pb      = 63'(l.p_cos) * 63'(COS_RCP[step]);
                n.q_cos = pb[62:32];
                if (step < SIN_TERMS)
                begin
                    pb      = 63'(l.p_sin) * 63'(SIN_RCP[step]);
                    n.q_sin = pb[62:32];
                end
            end
            default:
            begin
                qd      = 39'(l.q_cos) * 39'(COS_DIV[step]);
                r       = {1'b0, l.p_cos} - qd[31:0];
                corr    = r >= 32'(COS_DIV[step]);
                n.s_cos = Q30_ONE - (l.q_cos + Q30_W'(corr));
                if (step < SIN_TERMS)
                begin
                    qd      = 39'(l.q_sin) * 39'(SIN_DIV[step]);
                    r       = {1'b0, l.p_sin} - qd[31:0];
                    corr    = r >= 32'(SIN_DIV[step]);
                    n.s_sin = Q30_ONE - (l.q_sin + Q30_W'(corr));
                end
            end
        endcase
        return n;
    endfunction

    function automatic sc_t lane_sign(input lane_t l);
        sc_t                n;
        logic signed [31:0] s;
        logic signed [31:0] c;
        s = $signed({1'b0, l.swap ? l.s_cos : l.s_sin});
        c = $signed({1'b0, l.swap ? l.s_sin : l.s_cos});
        case (l.quad)
            QUAD_FIRST:
            begin
                n.sn = s;
                n.cs = c;
            end
            QUAD_SECOND:
            begin
                n.sn = c;
                n.cs = -s;
            end
            QUAD_THIRD:
            begin
                n.sn = -s;
                n.cs = -c;
            end
            default:
            begin
                n.sn = -c;
                n.cs = s;
            end
        endcase
        return n;
    endfunction

    logic [TRIG_LAST:0] valid_reg;
    trig_stage_t        stage_reg [0:TRIG_LAST];
    trig_stage_t        first_next;

    logic               out_valid_reg;
    sc_t                phi_reg, phi_next;
    sc_t                th_reg, th_next;
    side_t              side_reg;

    always_comb
    begin
        first_next.side = in_side;
        first_next.phi  = lane_fold(turn_phi);
        first_next.th   = lane_fold(turn_theta);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= {valid_reg[TRIG_LAST-1:0], in_valid};
            out_valid_reg <= valid_reg[TRIG_LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg[0] <= first_next;
    end

    for (genvar k = 1; k <= TRIG_LAST; k++)
    begin : g_stage
        localparam int STEP = (k - 3) / 3;
        localparam int SUB  = (k - 3) % 3;
        if (k == 1)
        begin : g_scale
            always_ff @(posedge clk)
            begin
                stage_reg[k].side <= stage_reg[k-1].side;
                stage_reg[k].phi  <= lane_scale(stage_reg[k-1].phi);
                stage_reg[k].th   <= lane_scale(stage_reg[k-1].th);
            end
        end
        else if (k == 2)
        begin : g_square
            always_ff @(posedge clk)
            begin
                stage_reg[k].side <= stage_reg[k-1].side;
                stage_reg[k].phi  <= lane_square(stage_reg[k-1].phi);
                stage_reg[k].th   <= lane_square(stage_reg[k-1].th);
            end
        end
        else
        begin : g_horner
            always_ff @(posedge clk)
            begin
                stage_reg[k].side <= stage_reg[k-1].side;
                stage_reg[k].phi  <= lane_horner(stage_reg[k-1].phi, STEP, SUB);
                stage_reg[k].th   <= lane_horner(stage_reg[k-1].th, STEP, SUB);
            end
        end
    end

    always_comb
    begin
        phi_next = lane_sign(stage_reg[TRIG_LAST].phi);
        th_next  = lane_sign(stage_reg[TRIG_LAST].th);
    end

    always_ff @(posedge clk)
    begin
        phi_reg  <= phi_next;
        th_reg   <= th_next;
        side_reg <= stage_reg[TRIG_LAST].side;
    end

    assign out_valid = out_valid_reg;
    assign sin_phi   = phi_reg.sn;
    assign cos_phi   = phi_reg.cs;
    assign sin_theta = th_reg.sn;
    assign cos_theta = th_reg.cs;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

// File: rtl/uvs_finish.sv
// position products, rounding, saturation and result register
`default_nettype none

module uvs_finish (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic signed [31:0] sin_phi,
    input  logic signed [31:0] cos_phi,
    input  logic signed [31:0] sin_theta,
    input  logic signed [31:0] cos_theta,
    input  uvs_pkg::side_t     in_side,
    output logic               out_valid,
    output uvs_pkg::result_t   res
);
    import uvs_pkg::*;

    localparam int          PROD_SHIFT = 60 - FRAC_BITS;
    localparam int          TRIG_SHIFT = 30 - FRAC_BITS;
    localparam logic [63:0] POS_LIMIT  = 64'd32767;
    localparam logic [63:0] NEG_LIMIT  = 64'd32768;

    // round half away from zero, then saturate
    function automatic logic [OUT_W-1:0] round_sat(input logic signed [63:0] v,
                                                   input int sh);
        logic [63:0]      mag;
        logic [OUT_W-1:0] r;
        mag = v[63] ? 64'(-v) : 64'(v);
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        if (v[63])
        begin
            r = (mag > NEG_LIMIT) ? 16'h8000 : OUT_W'(64'd0 - mag);
        end
        else
        begin
            r = (mag > POS_LIMIT) ? 16'h7fff : mag[OUT_W-1:0];
        end
        return r;
    endfunction

    logic               prod_valid_reg;
    logic signed [63:0] px_reg, px_next;
    logic signed [63:0] py_reg, py_next;
    logic signed [31:0] pz_reg;
    logic signed [31:0] tx_reg;
    logic signed [31:0] ty_reg;
    side_t              side_reg;

    logic               out_valid_reg;
    result_t            res_reg, res_next;

    assign px_next = sin_phi * cos_theta;
    assign py_next = sin_phi * sin_theta;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= in_valid;
            out_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg   <= px_next;
        py_reg   <= py_next;
        pz_reg   <= cos_phi;
        tx_reg   <= -sin_theta;
        ty_reg   <= cos_theta;
        side_reg <= in_side;
    end

    always_comb
    begin
        res_next = '0;
        if (side_reg.in_range)
        begin
            res_next.pos_x        = round_sat(px_reg, PROD_SHIFT);
            res_next.pos_y        = round_sat(py_reg, PROD_SHIFT);
            res_next.pos_z        = round_sat(64'(pz_reg), TRIG_SHIFT);
            res_next.tan_x        = round_sat(64'(tx_reg), TRIG_SHIFT);
            res_next.tan_y        = round_sat(64'(ty_reg), TRIG_SHIFT);
            res_next.tex_u        = side_reg.tex_u;
            res_next.tex_v        = side_reg.tex_v;
            res_next.vertex_index = side_reg.vertex_index;
            res_next.right_index  = side_reg.right_index;
            res_next.up_index     = side_reg.up_index;
            res_next.quad_valid   = side_reg.quad_valid;
            res_next.in_range     = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

// File: rtl/uv_sphere_vertex_generator.sv
// top level of the uv sphere vertex generator: register port, input stage and pipeline
`default_nettype none

// One request (stack_row, slice_col) can be taken in every clock cycle: busy is
// always low. Each request gives exactly one result, shown with done high for one
// cycle once the request has passed the input register, the 34 stage restoring divider
// and the sine and cosine pipeline with its 18 stage Horner evaluation. Results
// leave in request order and cannot be held off. Slice and stack counts are read
// when a request is taken, so they may only change while nothing is in flight.
module uv_sphere_vertex_generator (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 start,
    output logic                 busy,
    input  logic [9:0]           stack_row,
    input  logic [9:0]           slice_col,
    output logic                 done,
    output logic signed [15:0]   pos_x,
    output logic signed [15:0]   pos_y,
    output logic signed [15:0]   pos_z,
    output logic signed [15:0]   tan_x,
    output logic signed [15:0]   tan_y,
    output logic [16:0]          tex_u,
    output logic [16:0]          tex_v,
    output logic [19:0]          vertex_index,
    output logic [19:0]          right_index,
    output logic [19:0]          up_index,
    output logic                 quad_valid,
    output logic                 in_range
);
    import uvs_pkg::*;

    localparam logic REG_SLICE_COUNT = 1'b0;
    localparam logic REG_STACK_COUNT = 1'b1;
    localparam logic [CNT_W-1:0] COUNT_RESET = 10'd16;

    logic [CNT_W-1:0] slice_count_reg;
    logic [CNT_W-1:0] stack_count_reg;
    logic             reg_index;

    logic             in_valid_reg;
    logic [CNT_W-1:0] row_reg;
    logic [CNT_W-1:0] col_reg;
    logic [CNT_W-1:0] sl_reg;
    logic [CNT_W-1:0] st_reg;

    side_t            side_next;
    logic [CNT_W:0]   sl_plus_one;
    logic [IDX_W-1:0] idx;
    logic             grid_hit;
    logic             quad_hit;

    logic             div_valid;
    logic [TURN_W-1:0] turn_phi;
    logic [TURN_W-1:0] turn_theta;
    side_t            div_side;

    logic               trig_valid;
    logic signed [31:0] sin_phi;
    logic signed [31:0] cos_phi;
    logic signed [31:0] sin_theta;
    logic signed [31:0] cos_theta;
    side_t              trig_side;

    result_t          res;

    // register port
    assign reg_index = paddr[2];
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_count_reg <= COUNT_RESET;
            stack_count_reg <= COUNT_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_index)
                REG_SLICE_COUNT: slice_count_reg <= pwdata[CNT_W-1:0];
                REG_STACK_COUNT: stack_count_reg <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_SLICE_COUNT: prdata = 32'(slice_count_reg);
            REG_STACK_COUNT: prdata = 32'(stack_count_reg);
            default:         prdata = '0;
        endcase
    end

    // request stage
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= stack_row;
        col_reg <= slice_col;
        sl_reg  <= slice_count_reg;
        st_reg  <= stack_count_reg;
    end

    // grid checks and vertex indices
    always_comb
    begin
        grid_hit    = (sl_reg != '0) && (st_reg != '0) && (row_reg <= st_reg)
                      && (col_reg <= sl_reg);
        quad_hit    = grid_hit && (row_reg < st_reg) && (col_reg < sl_reg);
        sl_plus_one = {1'b0, sl_reg} + (CNT_W+1)'(1);
        idx         = IDX_W'(row_reg) * IDX_W'(sl_plus_one) + IDX_W'(col_reg);
        side_next   = '0;
        side_next.in_range   = grid_hit;
        side_next.quad_valid = quad_hit;
        if (grid_hit)
        begin
            side_next.vertex_index = idx;
        end
        if (quad_hit)
        begin
            side_next.right_index = idx + IDX_W'(1);
            side_next.up_index    = idx + IDX_W'(sl_plus_one);
        end
    end

    uvs_divider u_divider (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid_reg),
        .row        (row_reg),
        .stacks     (st_reg),
        .col        (col_reg),
        .slices     (sl_reg),
        .in_side    (side_next),
        .out_valid  (div_valid),
        .turn_phi   (turn_phi),
        .turn_theta (turn_theta),
        .out_side   (div_side)
    );

    uvs_trig u_trig (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (div_valid),
        .turn_phi   (turn_phi),
        .turn_theta (turn_theta),
        .in_side    (div_side),
        .out_valid  (trig_valid),
        .sin_phi    (sin_phi),
        .cos_phi    (cos_phi),
        .sin_theta  (sin_theta),
        .cos_theta  (cos_theta),
        .out_side   (trig_side)
    );

    uvs_finish u_finish (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (trig_valid),
        .sin_phi    (sin_phi),
        .cos_phi    (cos_phi),
        .sin_theta  (sin_theta),
        .cos_theta  (cos_theta),
        .in_side    (trig_side),
        .out_valid  (done),
        .res        (res)
    );

    assign pos_x        = res.pos_x;
    assign pos_y        = res.pos_y;
    assign pos_z        = res.pos_z;
    assign tan_x        = res.tan_x;
    assign tan_y        = res.tan_y;
    assign tex_u        = res.tex_u;
    assign tex_v        = res.tex_v;
    assign vertex_index = res.vertex_index;
    assign right_index  = res.right_index;
    assign up_index     = res.up_index;
    assign quad_valid   = res.quad_valid;
    assign in_range     = res.in_range;

endmodule

`default_nettype wire

// File: bench/uv_sphere_vertex_generator_test.sv
// self-checking bench for the uv sphere vertex generator: directed and random grid points
`default_nettype none

module uv_sphere_vertex_generator_test;
    import uvs_pkg::*;

    localparam int MAX_SEG = 1023;
    localparam int LATENCY = 70;
    localparam logic [2:0] ADDR_SLICES = 3'd0;
    localparam logic [2:0] ADDR_STACKS = 3'd4;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic start = 1'b0;
    logic busy;
    logic [9:0] stack_row = '0;
    logic [9:0] slice_col = '0;
    logic done;
    logic signed [15:0] pos_x, pos_y, pos_z, tan_x, tan_y;
    logic [16:0] tex_u, tex_v;
    logic [19:0] vertex_index, right_index, up_index;
    logic quad_valid, in_range;

    logic [9:0] cur_slices = 10'd16;
    logic [9:0] cur_stacks = 10'd16;
    result_t vertex_queue[$];
    int mismatches = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int idle_pct = 0;

    uv_sphere_vertex_generator DUT (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy), .stack_row(stack_row), .slice_col(slice_col),
        .done(done), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .tan_x(tan_x),
        .tan_y(tan_y), .tex_u(tex_u), .tex_v(tex_v), .vertex_index(vertex_index),
        .right_index(right_index), .up_index(up_index), .quad_valid(quad_valid),
        .in_range(in_range)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint unsigned turn_of(longint unsigned num, longint unsigned den);
        return (((num << 33) + den) / (den * 2)) & 64'hFFFF_FFFF;
    endfunction

    function automatic void sin_cos(input longint unsigned turn, output longint sn,
                                    output longint cs);
        longint unsigned one, q, f, g, x, x2, s, c, t;
        longint unsigned sdiv[5];
        longint unsigned cdiv[6];
        bit swap;
        one = 64'd1 << 30;
        sdiv = '{110, 72, 42, 20, 6};
        cdiv = '{132, 90, 56, 30, 12, 2};
        q = (turn >> 30) & 3;
        f = turn & (one - 1);
        swap = f > (one >> 1);
        g = swap ? one - f : f;
        x = (g * 64'd3373259426 + one) >> 31;
        x2 = (x * x) >> 30;
        s = one;
        c = one;
        for (int i = 0; i < 5; i++)
            s = one - ((x2 * s) >> 30) / sdiv[i];
        s = (x * s) >> 30;
        for (int i = 0; i < 6; i++)
            c = one - ((x2 * c) >> 30) / cdiv[i];
        if (swap)
        begin
            t = s;
            s = c;
            c = t;
        end
        case (q)
            0: begin sn = s; cs = c; end
            1: begin sn = c; cs = -longint'(c - c + s); end
            2: begin sn = -longint'(s); cs = -longint'(c); end
            default: begin sn = -longint'(c); cs = s; end
        endcase
    endfunction

    function automatic logic [15:0] round_q(longint v, int sh);
        longint unsigned mag;
        bit neg;
        neg = v < 0;
        mag = neg ? -v : v;
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        if (neg)
            return (mag > 32768) ? 16'h8000 : 16'(-longint'(mag));
        return (mag > 32767) ? 16'h7FFF : 16'(mag);
    endfunction

    function automatic result_t predict_vertex(logic [9:0] row, logic [9:0] col);
        result_t r;
        longint unsigned sl, st, idx;
        longint sp, cp, stt, ct;
        r = '0;
        sl = (cur_slices > MAX_SEG) ? MAX_SEG : cur_slices;
        st = (cur_stacks > MAX_SEG) ? MAX_SEG : cur_stacks;
        if (sl == 0 || st == 0 || row > st || col > sl)
            return r;
        sin_cos(turn_of(row, st * 2), sp, cp);
        sin_cos(turn_of(col, sl), stt, ct);
        r.pos_x = round_q(sp * ct, 60 - FRAC_BITS);
        r.pos_y = round_q(sp * stt, 60 - FRAC_BITS);
        r.pos_z = round_q(cp, 30 - FRAC_BITS);
        r.tan_x = round_q(-stt, 30 - FRAC_BITS);
        r.tan_y = round_q(ct, 30 - FRAC_BITS);
        r.tex_u = 17'((((64'(col)) << 17) + sl) / (sl * 2));
        r.tex_v = 17'((((64'(row)) << 17) + st) / (st * 2));
        idx = row * (sl + 1) + col;
        r.vertex_index = 20'(idx);
        r.quad_valid = row < st && col < sl;
        if (r.quad_valid)
        begin
            r.right_index = 20'(idx + 1);
            r.up_index = 20'(idx + sl + 1);
        end
        r.in_range = 1'b1;
        return r;
    endfunction

    function automatic bit field_ok(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v === act_v)
            return 1'b1;
        if (mismatches < 10)
            $display("mismatch %s: expected %0h, got %0h", name, exp_v, act_v);
        return 1'b0;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        result_t e;
        bit ok;
        if (rst_n && done)
        begin
            results_seen++;
            if (vertex_queue.size() == 0)
            begin
                if (mismatches < 10)
                    $display("result with no request outstanding");
                mismatches++;
            end
            else
            begin
                e = vertex_queue.pop_front();
                ok = 1'b1;
                ok &= field_ok("pos_x", 32'(e.pos_x), 32'($unsigned(pos_x)));
                ok &= field_ok("pos_y", 32'(e.pos_y), 32'($unsigned(pos_y)));
                ok &= field_ok("pos_z", 32'(e.pos_z), 32'($unsigned(pos_z)));
                ok &= field_ok("tan_x", 32'(e.tan_x), 32'($unsigned(tan_x)));
                ok &= field_ok("tan_y", 32'(e.tan_y), 32'($unsigned(tan_y)));
                ok &= field_ok("tex_u", 32'(e.tex_u), 32'(tex_u));
                ok &= field_ok("tex_v", 32'(e.tex_v), 32'(tex_v));
                ok &= field_ok("vertex_index", 32'(e.vertex_index), 32'(vertex_index));
                ok &= field_ok("right_index", 32'(e.right_index), 32'(right_index));
                ok &= field_ok("up_index", 32'(e.up_index), 32'(up_index));
                ok &= field_ok("quad_valid", 32'(e.quad_valid), 32'(quad_valid));
                ok &= field_ok("in_range", 32'(e.in_range), 32'(in_range));
                if (!ok)
                    mismatches++;
            end
        end
    end

    task automatic send_point(logic [9:0] row, logic [9:0] col);
        start <= 1'b1;
        stack_row <= row;
        slice_col <= col;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        vertex_queue.push_back(predict_vertex(row, col));
        requests_sent++;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
    endtask

    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (vertex_queue.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (addr == ADDR_SLICES)
            cur_slices = value[9:0];
        else
            cur_stacks = value[9:0];
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_grid(logic [31:0] slices, logic [31:0] stacks);
        write_reg(ADDR_SLICES, slices);
        write_reg(ADDR_STACKS, stacks);
    endtask

    task automatic test_reset_grid;
        send_point(10'd0, 10'd0);
        send_point(10'd16, 10'd16);
        send_point(10'd15, 10'd15);
        send_point(10'd8, 10'd4);
        send_point(10'd4, 10'd12);
        send_point(10'd17, 10'd0);
        send_point(10'd0, 10'd17);
        send_point(10'd1023, 10'd1023);
    endtask

    task automatic test_zero_counts;
        set_grid(32'd0, 32'd5);
        send_point(10'd0, 10'd0);
        set_grid(32'd5, 32'd0);
        send_point(10'd0, 10'd0);
    endtask

    task automatic test_extreme_counts;
        set_grid(32'hFFFF_FFFF, 32'hFFFF_FC01);
        send_point(10'd0, 10'd0);
        send_point(10'd1023, 10'd1023);
        send_point(10'd511, 10'd256);
        send_point(10'd512, 10'd768);
        set_grid(32'd1023, 32'd1023);
        send_point(10'd1022, 10'd1022);
        send_point(10'd341, 10'd682);
        set_grid(32'd1, 32'd1);
        send_point(10'd0, 10'd0);
        send_point(10'd1, 10'd1);
        send_point(10'd1, 10'd2);
    endtask

    task automatic test_random_grid;
        logic [9:0] sl, st, row, col;
        int pcts[3];
        pcts = '{0, 72, 8};
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin sl = 10'd1023; st = 10'd1023; end
                1: begin sl = 10'd3; st = 10'd2; end
                default:
                begin
                    sl = 10'($urandom_range(1023, 1));
                    st = 10'($urandom_range(1023, 1));
                end
            endcase
            set_grid(32'(sl), 32'(st));
            for (int p = 0; p < 3; p++)
            begin
                idle_pct = pcts[p];
                for (int n = 0; n < 58; n++)
                begin
                    if ($urandom_range(9) == 0)
                    begin
                        row = 10'($urandom);
                        col = 10'($urandom);
                    end
                    else
                    begin
                        row = 10'($urandom_range(st));
                        col = 10'($urandom_range(sl));
                    end
                    send_point(row, col);
                end
            end
        end
        idle_pct = 0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_grid();
        test_zero_counts();
        test_extreme_counts();
        test_random_grid();
        drain();
        $display("%0d requests sent, %0d results checked over zero, unit, maximum and random grids",
                 requests_sent, results_seen);
        $display("sender idling of 0, 8 and 72 percent, points inside and outside the grid");
        if (mismatches == 0 && vertex_queue.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
